// ===== hw/rtl/v3fp_pkg.sv =====
package v3fp_pkg;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_DOT  = 3'd2,
    FN_LEN  = 3'd3,
    FN_NORM = 3'd4,
    FN_LERP = 3'd5
  } func_t;

  // early results that travel alongside the root and divide pipelines
  typedef struct packed {
    func_t            op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] vec;
    logic [31:0]      scal;
    logic             flag;
  } pkt_t;

  typedef struct packed {
    logic [2:0][31:0] vec;
    logic [31:0]      scal;
    logic             flag;
  } res_t;

  // clamp to a signed wbits-wide word, return {clamped, low 32 bits}
  function automatic logic [32:0] sat_word(logic signed [71:0] v, int unsigned wbits);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    logic [32:0]        r;
    hi = (72'sd1 <<< (wbits - 1)) - 72'sd1;
    lo = -hi - 72'sd1;
    if (v > hi) begin
      r = {1'b1, hi[31:0]};
    end else if (v < lo) begin
      r = {1'b1, lo[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/v3fp_lane.sv =====
module v3fp_lane import v3fp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [31:0]    a_i,
  input  logic signed [31:0]    b_i,
  input  logic [FRAC_BITS:0]    t_i,
  output logic signed [63:0]    ab_o,
  output logic [63:0]           aa_o,
  output logic [32:0]           add_o,
  output logic [32:0]           sub_o,
  output logic [32:0]           lerp_o,
  output logic [31:0]           a_o
);

  localparam int LPW = 33 + FRAC_BITS + 2;

  logic signed [31:0]    a1_r, a2_r, a3_r;
  logic signed [32:0]    sum1_r, diff1_r, d1_r;
  logic [FRAC_BITS:0]    t1_r;
  logic signed [63:0]    ab1_r, aa1_r;
  logic [32:0]           add2_r, sub2_r, add3_r, sub3_r, lerp3_r;
  logic signed [LPW-1:0] lp2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= a_i;
      sum1_r  <= 33'(a_i) + 33'(b_i);
      diff1_r <= 33'(a_i) - 33'(b_i);
      d1_r    <= 33'(b_i) - 33'(a_i);
      t1_r    <= t_i;
      ab1_r   <= 64'(a_i) * 64'(b_i);
      aa1_r   <= 64'(a_i) * 64'(a_i);

      a2_r    <= a1_r;
      add2_r  <= sat_word(72'(sum1_r), WORD_BITS);
      sub2_r  <= sat_word(72'(diff1_r), WORD_BITS);
      // blend factor is never negative here
      lp2_r   <= LPW'(d1_r) * LPW'($signed({1'b0, t1_r}));

      a3_r    <= a2_r;
      add3_r  <= add2_r;
      sub3_r  <= sub2_r;
      lerp3_r <= sat_word(72'(a2_r) + 72'(lp2_r >>> FRAC_BITS), WORD_BITS);
    end
  end

  assign ab_o   = ab1_r;
  assign aa_o   = aa1_r;
  assign add_o  = add3_r;
  assign sub_o  = sub3_r;
  assign lerp_o = lerp3_r;
  assign a_o    = a3_r;

endmodule

// ===== hw/rtl/v3fp_sqrt.sv =====
module v3fp_sqrt import v3fp_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_i,
  input  logic [63:0]      rad_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [31:0]      root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int ST = 32;

  logic [63:0]      rad_r  [ST];
  logic [33:0]      rem_r  [ST];
  logic [31:0]      root_r [ST];
  logic [TAG_W-1:0] tag_r  [ST];
  logic [63:0]      rad_nxt  [ST];
  logic [33:0]      rem_nxt  [ST];
  logic [31:0]      root_nxt [ST];
  logic [TAG_W-1:0] tag_nxt  [ST];
  logic [ST-1:0]    v_r;

  // one result bit per stage, two radicand bits consumed per stage
  always_comb begin
    logic [63:0]      rad_p;
    logic [33:0]      rem_p;
    logic [31:0]      root_p;
    logic [TAG_W-1:0] tag_p;
    logic [35:0]      sh, trial, diff;
    logic             ge;
    for (int s = 0; s < ST; s++) begin
      if (s == 0) begin
        rad_p  = rad_i;
        rem_p  = '0;
        root_p = '0;
        tag_p  = tag_i;
      end else begin
        rad_p  = rad_r[s-1];
        rem_p  = rem_r[s-1];
        root_p = root_r[s-1];
        tag_p  = tag_r[s-1];
      end
      sh          = {rem_p, rad_p[63:62]};
      trial       = {2'b00, root_p, 2'b01};
      diff        = sh - trial;
      ge          = (sh >= trial);
      rad_nxt[s]  = {rad_p[61:0], 2'b00};
      rem_nxt[s]  = ge ? diff[33:0] : sh[33:0];
      root_nxt[s] = {root_p[30:0], ge};
      tag_nxt[s]  = tag_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ST-2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ST; s++) begin
        rad_r[s]  <= rad_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        tag_r[s]  <= tag_nxt[s];
      end
    end
  end

  assign v_o    = v_r[ST-1];
  assign root_o = root_r[ST-1];
  assign tag_o  = tag_r[ST-1];

endmodule

// ===== hw/rtl/v3fp_div.sv =====
module v3fp_div import v3fp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int TAG_W     = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            v_i,
  input  logic [2:0][32+FRAC_BITS-1:0]    num_i,
  input  logic [31:0]                     den_i,
  input  logic [TAG_W-1:0]                tag_i,
  output logic                            v_o,
  output logic [2:0][32+FRAC_BITS-1:0]    q_o,
  output logic [TAG_W-1:0]                tag_o
);

  localparam int QW = 32 + FRAC_BITS;

  logic [2:0][QW-1:0] num_r [QW];
  logic [2:0][31:0]   rem_r [QW];
  logic [2:0][QW-1:0] q_r   [QW];
  logic [31:0]        den_r [QW];
  logic [TAG_W-1:0]   tag_r [QW];
  logic [2:0][QW-1:0] num_nxt [QW];
  logic [2:0][31:0]   rem_nxt [QW];
  logic [2:0][QW-1:0] q_nxt   [QW];
  logic [31:0]        den_nxt [QW];
  logic [TAG_W-1:0]   tag_nxt [QW];
  logic [QW-1:0]      v_r;

  // restoring division, one quotient bit per stage, three components side by side
  always_comb begin
    logic [2:0][QW-1:0] num_p;
    logic [2:0][31:0]   rem_p;
    logic [2:0][QW-1:0] q_p;
    logic [31:0]        den_p;
    logic [TAG_W-1:0]   tag_p;
    logic [32:0]        sh, diff;
    logic               ge;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        num_p = num_i;
        rem_p = '0;
        q_p   = '0;
        den_p = den_i;
        tag_p = tag_i;
      end else begin
        num_p = num_r[s-1];
        rem_p = rem_r[s-1];
        q_p   = q_r[s-1];
        den_p = den_r[s-1];
        tag_p = tag_r[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        sh               = {rem_p[i], num_p[i][QW-1]};
        diff             = sh - {1'b0, den_p};
        ge               = (sh >= {1'b0, den_p});
        rem_nxt[s][i]    = ge ? diff[31:0] : sh[31:0];
        q_nxt[s][i]      = {q_p[i][QW-2:0], ge};
        num_nxt[s][i]    = {num_p[i][QW-2:0], 1'b0};
      end
      den_nxt[s] = den_p;
      tag_nxt[s] = tag_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        num_r[s] <= num_nxt[s];
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        den_r[s] <= den_nxt[s];
        tag_r[s] <= tag_nxt[s];
      end
    end
  end

  assign v_o   = v_r[QW-1];
  assign q_o   = q_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule

// ===== hw/rtl/vector3_fixed_point_unit_core.sv =====
// pipeline from input transaction to result valid:
//   3 lane/merge stages, 32 square-root stages, 32 + FRAC_BITS divide stages, output register
// throughput: one transaction per cycle while in_ready is high; the fully pipelined root and divider set the rate
// a two-entry output register/skid keeps input accepted while one result waits
// reset: synchronous active-low rst_n clears all valid bits, including the output and skid valid flags
module vector3_fixed_point_unit_core import v3fp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_blend,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_scalar,
  output logic               out_saturated
);

  localparam int TW    = FRAC_BITS + 1;
  localparam int QW    = 32 + FRAC_BITS;
  localparam int PKT_W = $bits(pkt_t);
  localparam int DT_W  = 32 + PKT_W;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic adv, acc, out_free;
  logic [TW-1:0] t_in;
  logic signed [31:0] a_in [3];
  logic signed [31:0] b_in [3];

  logic signed [63:0] ab [3];
  logic [63:0]        aa [3];
  logic [32:0]        add_res [3];
  logic [32:0]        sub_res [3];
  logic [32:0]        lerp_res [3];
  logic [31:0]        a3 [3];

  logic [2:0]         v_r;
  func_t              op1_r, op2_r, op3_r;
  logic signed [65:0] dot2_r;
  logic [63:0]        sq2_r, sq3_r;
  logic [32:0]        dot3_r;
  pkt_t               pk;

  logic               sq_v;
  logic [31:0]        len;
  logic [PKT_W-1:0]   sq_tag;
  pkt_t               pk_s;
  logic [2:0][QW-1:0] num;

  logic               dv_v;
  logic [2:0][QW-1:0] quo;
  logic [DT_W-1:0]    dv_tag;
  pkt_t               pk_f;
  logic [31:0]        len_f;
  res_t               res;

  logic               out_v_r, skid_v_r;
  res_t               out_q_r, skid_q_r;

  assign adv      = !skid_v_r;
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  assign a_in = '{in_a_x, in_a_y, in_a_z};
  assign b_in = '{in_b_x, in_b_y, in_b_z};

  always_comb begin
    if (in_blend < 32'sd0) begin
      t_in = '0;
    end else if (in_blend > ONE) begin
      t_in = ONE[TW-1:0];
    end else begin
      t_in = in_blend[TW-1:0];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3fp_lane #(
      .FRAC_BITS(FRAC_BITS),
      .WORD_BITS(WORD_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (adv),
      .a_i    (a_in[i]),
      .b_i    (b_in[i]),
      .t_i    (t_in),
      .ab_o   (ab[i]),
      .aa_o   (aa[i]),
      .add_o  (add_res[i]),
      .sub_o  (sub_res[i]),
      .lerp_o (lerp_res[i]),
      .a_o    (a3[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], acc};
    end
  end

  // merge: dot sum and sum of squares, exact before any rounding
  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r  <= func_t'(in_func);
      op2_r  <= op1_r;
      op3_r  <= op2_r;
      dot2_r <= 66'(ab[0]) + 66'(ab[1]) + 66'(ab[2]);
      sq2_r  <= aa[0] + aa[1] + aa[2];
      dot3_r <= sat_word(72'(dot2_r >>> FRAC_BITS), WORD_BITS);
      sq3_r  <= sq2_r;
    end
  end

  always_comb begin
    pk      = '0;
    pk.op   = op3_r;
    for (int i = 0; i < 3; i++) begin
      pk.a[i] = a3[i];
    end
    unique case (op3_r)
      FN_ADD: begin
        for (int i = 0; i < 3; i++) begin
          pk.vec[i] = add_res[i][31:0];
          pk.flag   = pk.flag | add_res[i][32];
        end
      end
      FN_SUB: begin
        for (int i = 0; i < 3; i++) begin
          pk.vec[i] = sub_res[i][31:0];
          pk.flag   = pk.flag | sub_res[i][32];
        end
      end
      FN_LERP: begin
        for (int i = 0; i < 3; i++) begin
          pk.vec[i] = lerp_res[i][31:0];
          pk.flag   = pk.flag | lerp_res[i][32];
        end
      end
      FN_DOT: begin
        pk.scal = dot3_r[31:0];
        pk.flag = dot3_r[32];
      end
      default: begin
      end
    endcase
  end

  v3fp_sqrt #(
    .TAG_W(PKT_W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .v_i    (v_r[2]),
    .rad_i  (sq3_r),
    .tag_i  (pk),
    .v_o    (sq_v),
    .root_o (len),
    .tag_o  (sq_tag)
  );

  // numerators are |a| scaled by one, sign restored after the divide
  always_comb begin
    logic [31:0] mag;
    pk_s = pkt_t'(sq_tag);
    for (int i = 0; i < 3; i++) begin
      mag    = pk_s.a[i][31] ? (~pk_s.a[i] + 32'd1) : pk_s.a[i];
      num[i] = {mag, {FRAC_BITS{1'b0}}};
    end
  end

  v3fp_div #(
    .FRAC_BITS(FRAC_BITS),
    .TAG_W    (DT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .v_i   (sq_v),
    .num_i (num),
    .den_i (len),
    .tag_i ({len, sq_tag}),
    .v_o   (dv_v),
    .q_o   (quo),
    .tag_o (dv_tag)
  );

  always_comb begin
    logic signed [QW:0] qs;
    logic [32:0]        st;
    qs        = '0;
    st        = '0;
    pk_f      = pkt_t'(dv_tag[PKT_W-1:0]);
    len_f     = dv_tag[DT_W-1:PKT_W];
    res.vec   = pk_f.vec;
    res.scal  = pk_f.scal;
    res.flag  = pk_f.flag;
    unique case (pk_f.op)
      FN_LEN: begin
        st       = sat_word(72'(len_f), WORD_BITS);
        res.scal = st[31:0];
        res.flag = st[32];
      end
      FN_NORM: begin
        res = '0;
        // zero length leaves the zero vector
        if (len_f != 32'd0) begin
          for (int i = 0; i < 3; i++) begin
            qs = $signed({1'b0, quo[i]});
            if (pk_f.a[i][31]) begin
              qs = -qs;
            end
            st         = sat_word(72'(qs), WORD_BITS);
            res.vec[i] = st[31:0];
            res.flag   = res.flag | st[32];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register plus skid entry
  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= dv_v;
      end
    end else if (dv_v && adv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_q_r <= skid_v_r ? skid_q_r : res;
    end
    if (!out_free && adv) begin
      skid_q_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_r_x       = out_q_r.vec[0];
  assign out_r_y       = out_q_r.vec[1];
  assign out_r_z       = out_q_r.vec[2];
  assign out_scalar    = out_q_r.scal;
  assign out_saturated = out_q_r.flag;

endmodule
